// ===== design/pwmps_pkg.sv =====
// ----------------------------------------------------------------------------
// pwmps_pkg
// Shared types and constants for the PWM prescaler and period setup block.
// ----------------------------------------------------------------------------
package pwmps_pkg;

  // request operations
  localparam logic [1:0] OP_CONFIGURE = 2'd0;
  localparam logic [1:0] OP_SET_PULSE = 2'd1;
  localparam logic [1:0] OP_ENABLE    = 2'd2;
  localparam logic [1:0] OP_DISABLE   = 2'd3;

  // response status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_INVALID    = 2'd1;
  localparam logic [1:0] ST_NOT_CONFIG = 2'd2;

  // clock register
  localparam int          CLK_W     = 27;
  localparam logic [26:0] CLK_RESET = 27'd48000000;

  // product of clock and nanoseconds, and the rounded dividend
  localparam int PROD_W  = 59;
  localparam int DIV_N_W = 60;
  localparam int DIV_Q_W = 30;
  localparam int DIV_CNT_W = 2;

  localparam logic [29:0] NS_PER_S = 30'd1000000000;
  localparam logic [59:0] HALF_NS  = 60'd500000000;

  // reciprocal estimate: top 32 dividend bits times floor(2^58 / 1e9),
  // dropped by 30 bits, is never high and at most one low
  localparam int          DIV_EST_LSB = 28;
  localparam int          EST_W       = 62;
  localparam logic [29:0] DIV_RECIP   = 30'd288230376;

  // prescaler divisors 1,2,4,8,16,64,256,1024 as shift amounts
  localparam logic [3:0] PSC_SHIFT [8] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd8, 4'd10
  };

  // sequencer states
  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CHECK  = 8'b0000_0010,
    S_MUL    = 8'b0000_0100,
    S_SEARCH = 8'b0000_1000,
    S_LOAD   = 8'b0001_0000,
    S_DIV    = 8'b0010_0000,
    S_FINISH = 8'b0100_0000,
    S_RESP   = 8'b1000_0000
  } state_e;

  // divider control and status
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic done;
  } div_sts_t;

endpackage

// ===== design/pwmps_div.sv =====
// ----------------------------------------------------------------------------
// pwmps_div
// Division of a 60-bit dividend by one second in nanoseconds: a reciprocal
// estimate, a multiply back, a remainder and one correction.
// ----------------------------------------------------------------------------
module pwmps_div import pwmps_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  div_ctl_t             ctl_i,
  input  logic [DIV_N_W-1:0]   dividend_i,
  output div_sts_t             sts_o,
  output logic [DIV_Q_W-1:0]   quotient_o
);

  // step codes
  localparam logic [DIV_CNT_W-1:0] STEP_EST  = 2'd0;
  localparam logic [DIV_CNT_W-1:0] STEP_BACK = 2'd1;
  localparam logic [DIV_CNT_W-1:0] STEP_REM  = 2'd2;
  localparam logic [DIV_CNT_W-1:0] STEP_FIX  = 2'd3;

  logic [DIV_N_W-1:0]   num_q;
  logic [DIV_N_W-1:0]   back_q;
  logic [DIV_Q_W:0]     rem_q;
  logic [DIV_Q_W-1:0]   quo_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;
  logic [EST_W-1:0]     est_p;
  logic [DIV_N_W-1:0]   back_p;
  logic [DIV_N_W-1:0]   diff;
  logic                 ge;

  // estimate, multiply back and remainder; the remainder is below two seconds
  assign est_p  = EST_W'(num_q[DIV_N_W-1:DIV_EST_LSB]) * EST_W'(DIV_RECIP);
  assign back_p = DIV_N_W'(quo_q) * DIV_N_W'(NS_PER_S);
  assign diff   = num_q - back_q;
  assign ge     = rem_q >= {1'b0, NS_PER_S};

  // step counter and status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !ctl_i.start && (cnt_q == STEP_FIX);
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= STEP_EST;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == STEP_FIX) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      num_q <= dividend_i;
    end else if (busy_q) begin
      case (cnt_q)
        STEP_EST:  quo_q  <= est_p[2*DIV_Q_W-1:DIV_Q_W];
        STEP_BACK: back_q <= back_p;
        STEP_REM:  rem_q  <= diff[DIV_Q_W:0];
        STEP_FIX:  quo_q  <= quo_q + DIV_Q_W'(ge);
        default: begin
        end
      endcase
    end
  end

  assign sts_o.done = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== design/pwm_prescaler_and_period_setup.sv =====
// ----------------------------------------------------------------------------
// pwm_prescaler_and_period_setup
// PWM request handler: converts period and pulse in nanoseconds into timer
// counts and picks the smallest prescaler whose period count fits.
// ----------------------------------------------------------------------------
// One request is taken at a time and answered with one result beat. Enable,
// disable and requests that fail the argument check go from the check state
// straight to the result state. Set pulse and configure use one shared 27x32
// multiplier per conversion, configure adds one fit compare per tried
// prescaler (one to eight), and the reciprocal divider holds the sequencer
// for each rounded count. A stalled result beat holds the next request in
// the result state.
// The clock register may be written whenever no request is open.
module pwm_prescaler_and_period_setup import pwmps_pkg::*; #(
  parameter int OUTPUT_COUNT = 1,
  parameter int COUNTER_BITS = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // clock frequency register
  input  logic              cfg_we_i,
  input  logic [CLK_W-1:0]  cfg_wdata_i,
  // request channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        operation_i,
  input  logic [2:0]        output_select_i,
  input  logic [31:0]       period_ns_i,
  input  logic [31:0]       pulse_ns_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [23:0]       period_count_o,
  output logic [23:0]       compare_count_o,
  output logic [2:0]        prescaler_select_o,
  output logic              running_o,
  output logic              configured_flag_o
);

  localparam int IDX_W = (OUTPUT_COUNT > 1) ? $clog2(OUTPUT_COUNT) : 1;
  localparam int CW    = COUNTER_BITS;
  // shifted product must stay below this for the rounded count to fit
  localparam logic [63:0] FIT_LIMIT =
    ((64'd1 << COUNTER_BITS) * 64'd1000000000) - 64'd500000000;

  state_e              state_q;
  logic [CLK_W-1:0]    clk_hz_q;
  logic                pul_phase_q;
  logic [2:0]          s_idx_q;
  logic                inv_q;
  logic [1:0]          st_q;
  logic                out_valid_q;

  logic [1:0]          op_q;
  logic [2:0]          sel_q;
  logic [31:0]         per_q, pul_q;
  logic [PROD_W-1:0]   prod_q;
  logic [CW-1:0]       pc_new_q;

  // per-output state
  logic                cfgd_q [OUTPUT_COUNT];
  logic                en_q   [OUTPUT_COUNT];
  logic [2:0]          psc_q  [OUTPUT_COUNT];
  logic [31:0]         pns_q  [OUTPUT_COUNT];
  logic [CW-1:0]       pcnt_q [OUTPUT_COUNT];
  logic [CW-1:0]       ccnt_q [OUTPUT_COUNT];

  logic [1:0]          status_q;
  logic [23:0]         period_count_q, compare_count_q;
  logic [2:0]          prescaler_select_q;
  logic                running_q, configured_flag_q;

  logic                in_fire, out_free, sel_ok;
  logic [IDX_W-1:0]    idx;
  logic [PROD_W-1:0]   prod;
  logic [63:0]         shifted;
  logic                fits;
  logic [DIV_N_W-1:0]  div_n;
  logic [DIV_Q_W-1:0]  quot;
  logic [31:0]         q_ext, pc_ref;
  div_ctl_t            div_ctl;
  div_sts_t            div_sts;

  assign in_fire  = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign sel_ok   = 32'(sel_q) < OUTPUT_COUNT;
  assign idx      = sel_q[IDX_W-1:0];

  // shared multiplier, fit compare and rounded dividend
  assign prod    = PROD_W'(clk_hz_q) * PROD_W'(pul_phase_q ? pul_q : per_q);
  assign shifted = 64'(prod_q >> PSC_SHIFT[s_idx_q]);
  assign fits    = shifted < FIT_LIMIT;
  assign div_n   = shifted[DIV_N_W-1:0] + HALF_NS;

  assign div_ctl.start = (state_q == S_LOAD);

  pwmps_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .dividend_i (div_n),
    .sts_o      (div_sts),
    .quotient_o (quot)
  );

  assign q_ext  = 32'(quot);
  assign pc_ref = (op_q == OP_CONFIGURE) ? 32'(pc_new_q) : 32'(pcnt_q[idx]);

  // clock frequency register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_hz_q <= CLK_RESET;
    end else if (cfg_we_i) begin
      clk_hz_q <= cfg_wdata_i;
    end
  end

  // sequencer and per-output state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pul_phase_q <= 1'b0;
      s_idx_q     <= '0;
      inv_q       <= 1'b0;
      st_q        <= ST_OK;
      out_valid_q <= 1'b0;
      for (int i = 0; i < OUTPUT_COUNT; i++) begin
        cfgd_q[i] <= 1'b0;
        en_q[i]   <= 1'b0;
        psc_q[i]  <= '0;
        pns_q[i]  <= '0;
        pcnt_q[i] <= '0;
        ccnt_q[i] <= '0;
      end
    end else begin
      if (state_q == S_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            inv_q   <= 1'b0;
            st_q    <= ST_OK;
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (!sel_ok) begin
            inv_q   <= 1'b1;
            st_q    <= ST_INVALID;
            state_q <= S_RESP;
          end else if (op_q == OP_CONFIGURE) begin
            if (per_q == '0 || pul_q > per_q) begin
              st_q    <= ST_INVALID;
              state_q <= S_RESP;
            end else begin
              pul_phase_q <= 1'b0;
              s_idx_q     <= '0;
              state_q     <= S_MUL;
            end
          end else if (!cfgd_q[idx]) begin
            st_q    <= ST_NOT_CONFIG;
            state_q <= S_RESP;
          end else if (op_q == OP_SET_PULSE) begin
            if (pul_q > pns_q[idx]) begin
              st_q    <= ST_INVALID;
              state_q <= S_RESP;
            end else begin
              pul_phase_q <= 1'b1;
              s_idx_q     <= psc_q[idx];
              state_q     <= S_MUL;
            end
          end else begin
            en_q[idx] <= (op_q == OP_ENABLE);
            state_q   <= S_RESP;
          end
        end
        S_MUL: begin
          state_q <= pul_phase_q ? S_LOAD : S_SEARCH;
        end
        // try prescalers in order until the period count fits or the last one fails
        S_SEARCH: begin
          if (fits) begin
            state_q <= S_LOAD;
          end else if (s_idx_q == 3'd7) begin
            st_q    <= ST_INVALID;
            state_q <= S_RESP;
          end else begin
            s_idx_q <= s_idx_q + 1'b1;
          end
        end
        S_LOAD: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_sts.done) begin
            state_q <= S_FINISH;
          end
        end
        // period count done: convert the pulse; pulse count done: commit, or reject if above the period count
        S_FINISH: begin
          if (!pul_phase_q) begin
            pul_phase_q <= 1'b1;
            state_q     <= S_MUL;
          end else if (q_ext > pc_ref) begin
            st_q    <= ST_INVALID;
            state_q <= S_RESP;
          end else begin
            ccnt_q[idx] <= q_ext[CW-1:0];
            if (op_q == OP_CONFIGURE) begin
              psc_q[idx]  <= s_idx_q;
              pns_q[idx]  <= per_q;
              pcnt_q[idx] <= pc_new_q;
              cfgd_q[idx] <= 1'b1;
            end
            state_q <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // request payload and intermediate values
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= operation_i;
      sel_q <= output_select_i;
      per_q <= period_ns_i;
      pul_q <= pulse_ns_i;
    end
    if (state_q == S_MUL) begin
      prod_q <= prod;
    end
    if (state_q == S_FINISH && !pul_phase_q) begin
      pc_new_q <= (quot == '0) ? CW'(1) : q_ext[CW-1:0];
    end
  end

  // result beat register
  always_ff @(posedge clk_i) begin
    if (state_q == S_RESP && out_free) begin
      status_q <= st_q;
      if (inv_q) begin
        period_count_q     <= '0;
        compare_count_q    <= '0;
        prescaler_select_q <= '0;
        running_q          <= 1'b0;
        configured_flag_q  <= 1'b0;
      end else begin
        period_count_q     <= 24'(pcnt_q[idx]);
        compare_count_q    <= 24'(ccnt_q[idx]);
        prescaler_select_q <= psc_q[idx];
        running_q          <= en_q[idx];
        configured_flag_q  <= cfgd_q[idx];
      end
    end
  end

  assign in_stall_o         = (state_q != S_IDLE);
  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign period_count_o     = period_count_q;
  assign compare_count_o    = compare_count_q;
  assign prescaler_select_o = prescaler_select_q;
  assign running_o          = running_q;
  assign configured_flag_o  = configured_flag_q;

endmodule

// ===== test/tb_pwm_prescaler_and_period_setup.sv =====
// ----------------------------------------------------------------------------
// tb_pwm_prescaler_and_period_setup
// Self-checking bench for the PWM request handler. Requests are driven over
// the valid/stall channel, a scoreboard predicts each response beat from its
// own copy of the per-output state and the clock register, and every response
// is compared field by field. Several clock settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_pwm_prescaler_and_period_setup import pwmps_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned OUT_COUNT  = 1;
  localparam bit [63:0]   COUNT_MAX  = (64'd1 << 24) - 64'd1;
  localparam int unsigned PHASES     = 8;
  localparam int unsigned PHASE_REQS = 104;

  typedef struct packed {
    logic [1:0]  status;
    logic [23:0] period_count;
    logic [23:0] compare_count;
    logic [2:0]  prescaler;
    logic        running;
    logic        configured;
  } pwm_resp_t;

  // prediction of the response stream
  class pwm_scoreboard;
    bit [26:0]   clock_hz;
    bit          is_cfg;
    bit          is_en;
    bit [2:0]    psc;
    bit [31:0]   per_ns;
    bit [23:0]   per_cnt;
    bit [23:0]   cmp_cnt;
    pwm_resp_t   resp_q[$];
    int unsigned errors;
    int unsigned checked;
    bit [7:0]    psc_seen;

    function new();
      clock_hz = CLK_RESET;
      is_cfg   = 1'b0;
      is_en    = 1'b0;
      psc      = '0;
      per_ns   = '0;
      per_cnt  = '0;
      cmp_cnt  = '0;
      errors   = 0;
      checked  = 0;
      psc_seen = '0;
    endfunction

    function int unsigned div_shift(bit [2:0] idx);
      case (idx)
        3'd5:    return 6;
        3'd6:    return 8;
        3'd7:    return 10;
        default: return idx;
      endcase
    endfunction

    // rounded timer ticks of ns at divisor index idx
    function bit [63:0] ns_to_ticks(bit [31:0] ns, bit [2:0] idx);
      bit [63:0] den;
      den = 64'd1000000000 << div_shift(idx);
      return ({37'd0, clock_hz} * {32'd0, ns} + (den >> 1)) / den;
    endfunction

    function int unsigned pending();
      return resp_q.size();
    endfunction

    function void note_request(bit [1:0] op, bit [2:0] sel, bit [31:0] period,
                               bit [31:0] pulse);
      pwm_resp_t r;
      bit [63:0] pc;
      bit [63:0] try_pc;
      bit [63:0] cc;
      bit        found;
      bit [2:0]  chosen;
      bit [1:0]  st;
      st     = ST_OK;
      found  = 1'b0;
      chosen = '0;
      pc     = '0;
      r      = '0;
      // output out of range: all zero, invalid
      if (sel >= OUT_COUNT) begin
        r.status = ST_INVALID;
        resp_q.push_back(r);
        return;
      end
      if (op == OP_CONFIGURE) begin
        if (period == 0 || pulse > period) begin
          st = ST_INVALID;
        end else begin
          // first divisor whose period count fits
          for (int k = 0; k < 8; k++) begin
            if (!found) begin
              try_pc = ns_to_ticks(period, k[2:0]);
              if (try_pc == 0) try_pc = 64'd1;
              if (try_pc <= COUNT_MAX) begin
                found  = 1'b1;
                chosen = k[2:0];
                pc     = try_pc;
              end
            end
          end
          if (!found) begin
            st = ST_INVALID;
          end else begin
            cc = ns_to_ticks(pulse, chosen);
            if (cc > COUNT_MAX || cc > pc) begin
              st = ST_INVALID;
            end else begin
              psc      = chosen;
              per_ns   = period;
              per_cnt  = pc[23:0];
              cmp_cnt  = cc[23:0];
              is_cfg   = 1'b1;
              psc_seen[chosen] = 1'b1;
            end
          end
        end
      end else if (!is_cfg) begin
        st = ST_NOT_CONFIG;
      end else if (op == OP_SET_PULSE) begin
        if (pulse > per_ns) begin
          st = ST_INVALID;
        end else begin
          cc = ns_to_ticks(pulse, psc);
          if (cc > COUNT_MAX || cc > {40'd0, per_cnt}) st = ST_INVALID;
          else cmp_cnt = cc[23:0];
        end
      end else if (op == OP_ENABLE) begin
        is_en = 1'b1;
      end else begin
        is_en = 1'b0;
      end
      r.status        = st;
      r.period_count  = per_cnt;
      r.compare_count = cmp_cnt;
      r.prescaler     = psc;
      r.running       = is_en;
      r.configured    = is_cfg;
      resp_q.push_back(r);
    endfunction

    task report(string what, longint unsigned got, longint unsigned exp_v);
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what,
               got, exp_v);
      errors++;
    endtask

    task check_response(pwm_resp_t got);
      pwm_resp_t exp_r;
      if (resp_q.size() == 0) begin
        report("unexpected response beat", got, 0);
        return;
      end
      exp_r = resp_q.pop_front();
      checked++;
      if (got.status !== exp_r.status) report("status", got.status, exp_r.status);
      if (got.period_count !== exp_r.period_count)
        report("period_count", got.period_count, exp_r.period_count);
      if (got.compare_count !== exp_r.compare_count)
        report("compare_count", got.compare_count, exp_r.compare_count);
      if (got.prescaler !== exp_r.prescaler)
        report("prescaler_select", got.prescaler, exp_r.prescaler);
      if (got.running !== exp_r.running) report("running", got.running, exp_r.running);
      if (got.configured !== exp_r.configured)
        report("configured_flag", got.configured, exp_r.configured);
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [26:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  operation_i;
  logic [2:0]  output_select_i;
  logic [31:0] period_ns_i;
  logic [31:0] pulse_ns_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [23:0] period_count_o;
  logic [23:0] compare_count_o;
  logic [2:0]  prescaler_select_o;
  logic        running_o;
  logic        configured_flag_o;

  pwm_scoreboard sb = new();
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_stall_pct = 0;
  int unsigned   reqs_sent = 0;
  int unsigned   clock_writes = 0;

  pwm_prescaler_and_period_setup dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .operation_i        (operation_i),
    .output_select_i    (output_select_i),
    .period_ns_i        (period_ns_i),
    .pulse_ns_i         (pulse_ns_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .period_count_o     (period_count_o),
    .compare_count_o    (compare_count_o),
    .prescaler_select_o (prescaler_select_o),
    .running_o          (running_o),
    .configured_flag_o  (configured_flag_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // response side stall
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // response beat check
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      sb.check_response({status_o, period_count_o, compare_count_o, prescaler_select_o,
                         running_o, configured_flag_o});
    end
  end

  // one request beat, with random sender gaps
  task automatic send_req(input bit [1:0] op, input bit [2:0] sel,
                          input bit [31:0] per, input bit [31:0] pul);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    operation_i     <= op;
    output_select_i <= sel;
    period_ns_i     <= per;
    pulse_ns_i      <= pul;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    sb.note_request(op, sel, per, pul);
    reqs_sent++;
  endtask

  // hold off the sender until every response is back
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // clock register write while idle
  task automatic write_clock(input bit [26:0] hz);
    drain();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= hz;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.clock_hz = hz;
    clock_writes++;
  endtask

  // period close to where the count crosses the 24-bit limit at divisor 2^k
  function automatic bit [31:0] fit_boundary_ns(int unsigned k);
    bit [63:0] v;
    if (sb.clock_hz == 0) return $urandom;
    v = (64'd33554431 * (64'd1000000000 << k)) / (64'd2 * sb.clock_hz);
    if (v > 64'hFFFF_FFF0) return $urandom;
    v = v + $urandom_range(4) - 2;
    return v[31:0];
  endfunction

  // mostly well-formed requests with random content, some noise
  task automatic rand_request();
    bit [1:0]  op;
    bit [2:0]  sel;
    bit [31:0] per;
    bit [31:0] pul;
    bit [31:0] ref_per;
    bit [63:0] over;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35)      op = OP_CONFIGURE;
    else if (r < 65) op = OP_SET_PULSE;
    else if (r < 82) op = OP_ENABLE;
    else             op = OP_DISABLE;
    sel = ($urandom_range(99) < 8) ? 3'($urandom_range(7, 1)) : 3'd0;
    r = $urandom_range(99);
    if (r < 25)      per = $urandom_range(2000, 1);
    else if (r < 50) per = $urandom_range(400000000, 1);
    else if (r < 88) per = $urandom;
    else if (r < 96) per = fit_boundary_ns($urandom_range(4));
    else             per = '0;
    ref_per = (op == OP_SET_PULSE) ? sb.per_ns : per;
    r = $urandom_range(99);
    if (r < 80) begin
      pul = $urandom_range(ref_per);
    end else if (r < 88) begin
      pul = ref_per;
    end else if (r < 96) begin
      over = {32'd0, ref_per} + $urandom_range(1000, 1);
      pul  = (over > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : over[31:0];
    end else begin
      pul = $urandom;
    end
    send_req(op, sel, per, pul);
  endtask

  // main sequence
  initial begin
    bit [26:0] clocks [PHASES];
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    operation_i     = OP_CONFIGURE;
    output_select_i = '0;
    period_ns_i     = '0;
    pulse_ns_i      = '0;
    clocks = '{27'd100000000, 27'd1, 27'd0, 27'd48000000,
               27'($urandom_range(100000000, 1)), 27'($urandom_range(1000000, 1)),
               27'($urandom_range(100000000, 1)), 27'($urandom_range(100000000, 10000000))};
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: not configured, rejects, extremes, repeats, fit boundary
    send_req(OP_SET_PULSE, 3'd0, 32'd0, 32'd0);
    send_req(OP_ENABLE,    3'd0, 32'd0, 32'd0);
    send_req(OP_DISABLE,   3'd0, 32'd0, 32'd0);
    send_req(OP_CONFIGURE, 3'd7, 32'd1000, 32'd10);
    send_req(OP_CONFIGURE, 3'd0, 32'd0, 32'd0);
    send_req(OP_CONFIGURE, 3'd0, 32'd1000, 32'd1001);
    send_req(OP_CONFIGURE, 3'd0, 32'd1, 32'd0);
    send_req(OP_CONFIGURE, 3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(OP_CONFIGURE, 3'd0, 32'hFFFF_FFFF, 32'd0);
    send_req(OP_CONFIGURE, 3'd0, 32'd1000, 32'd1000);
    send_req(OP_ENABLE,    3'd0, 32'd0, 32'd0);
    send_req(OP_ENABLE,    3'd0, 32'd0, 32'd0);
    send_req(OP_CONFIGURE, 3'd0, 32'd20000, 32'd5000);
    send_req(OP_SET_PULSE, 3'd0, 32'd0, 32'hFFFF_FFFF);
    send_req(OP_SET_PULSE, 3'd0, 32'hFFFF_FFFF, 32'd0);
    send_req(OP_SET_PULSE, 3'd0, 32'd0, 32'd20000);
    send_req(OP_DISABLE,   3'd0, 32'd0, 32'd0);
    send_req(OP_DISABLE,   3'd0, 32'd0, 32'd0);
    send_req(OP_CONFIGURE, 3'd0, 32'd349525322, 32'd349525322);
    send_req(OP_CONFIGURE, 3'd0, 32'd349525323, 32'd174762661);
    send_req(OP_SET_PULSE, 3'd3, 32'd0, 32'd100);
    send_req(OP_ENABLE,    3'd1, 32'd0, 32'd0);
    send_req(OP_DISABLE,   3'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // random phases over clock settings and idle mixes
    for (int p = 0; p < PHASES; p++) begin
      write_clock(clocks[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      for (int i = 0; i < PHASE_REQS; i++) begin
        if ($urandom_range(49) == 0) drain();
        rand_request();
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    $display("covered %0d requests, %0d responses checked, %0d clock register writes",
             reqs_sent, sb.checked, clock_writes);
    $display("prescaler indexes chosen by configure: %b", sb.psc_seen);
    if (sb.errors == 0) begin
      $display("[pwm_prescaler_and_period_setup] OK");
    end else begin
      $display("[pwm_prescaler_and_period_setup] ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("[pwm_prescaler_and_period_setup] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
design/pwmps_pkg.sv
design/pwmps_div.sv
design/pwm_prescaler_and_period_setup.sv
test/tb_pwm_prescaler_and_period_setup.sv
